@@ sv/msup_pkg.sv @@
// ----------------------------------------------------------------------------
// msup_pkg
// Types, codes and helpers shared by the motion safety supervisor modules.
// ----------------------------------------------------------------------------
package msup_pkg;

    localparam int unsigned TickW    = 32;
    localparam int unsigned SwitchW  = 6;
    localparam int unsigned FlagW    = 8;
    localparam int unsigned CycleW   = 8;
    localparam int unsigned InDataW  = 48;
    localparam int unsigned OutDataW = 16;

    localparam logic [CycleW-1:0] MaxCycleReset = 8'd4;

    // request kinds carried on the input tuser bit
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // mode codes as reported in the result
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_WATCHING = 2'd1;
    localparam logic [1:0] MODE_STOPPING = 2'd2;
    localparam logic [1:0] MODE_ERROR    = 2'd3;

    // error flag values
    localparam logic [FlagW-1:0] FLAG_SECURITY = 8'h01;
    localparam logic [FlagW-1:0] FLAG_OVERRUN  = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_WATCHING = 4'b0010,
        ST_STOPPING = 4'b0100,
        ST_ERROR    = 4'b1000
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic [TickW-1:0]   tick_now;
        logic               motor_waiting;
        logic               movement_waiting;
        logic               motor_faulted;
        logic               movement_faulted;
        logic               homing_active;
        logic [SwitchW-1:0] limit_switches;
        logic               motor_stopped;
        logic               movement_stopped;
    } t_in_item;

    typedef struct packed {
        logic [FlagW-1:0] error_flags;
        logic             clear_errors;
        logic             subsystem_reset;
        logic             stop_request;
        logic             pass_grant;
        logic [1:0]       mode;
    } t_result;

    function automatic logic [1:0] mode_code(input t_state st);
        logic [1:0] code;
        code = MODE_IDLE;
        case (st)
            ST_IDLE:     code = MODE_IDLE;
            ST_WATCHING: code = MODE_WATCHING;
            ST_STOPPING: code = MODE_STOPPING;
            ST_ERROR:    code = MODE_ERROR;
            default:     code = MODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ sv/motion_safety_supervisor_core.sv @@
// ----------------------------------------------------------------------------
// motion_safety_supervisor_core
// Safety supervisor for a motorized joint, one result beat per input beat.
// ----------------------------------------------------------------------------
// Input beats arrive on the s channel: tuser is the request kind (0 task
// tick, 1 reset request), tdata carries the tick count and subsystem status.
// Every input beat yields exactly one result beat on the m channel with the
// mode after the step, the pass/stop/reset commands and the error flags.
// The cfg channel writes max_cycle_ticks; it is always ready and should be
// written only while no beat is in flight.
// Each beat passes an input register, then the supervisor logic (one
// 32-bit subtract and compare plus a few gates) into the result register.
// Throughput is one beat per cycle unless stalled; state updates per beat.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; s tready drops once both are full.
// Synchronous active-low reset returns to idle, clears the reset latch and
// the last tick, sets max_cycle_ticks to 4 and empties both registers.
// ----------------------------------------------------------------------------
module motion_safety_supervisor_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [31:0] tick_now, [32] motor_waiting, [33] movement_waiting,
    // [34] motor_faulted, [35] movement_faulted, [36] homing_active,
    // [42:37] limit_switches, [43] motor_stopped, [44] movement_stopped
    input  logic [msup_pkg::InDataW-1:0]    i_s_tdata,
    // [0] cmd
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] mode, [2] pass_grant, [3] stop_request, [4] subsystem_reset,
    // [5] clear_errors, [13:6] error_flags
    output logic [msup_pkg::OutDataW-1:0]   o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [msup_pkg::CycleW-1:0]     i_cfg_data
);
    import msup_pkg::*;

    logic                r_in_valid;
    t_in_item            r_in_item, n_in_item;
    logic                r_out_valid;
    t_result             r_out;
    t_result             step_result;
    logic [CycleW-1:0]   r_max_cycle;
    logic                out_adv;
    logic                fire;
    logic                s_accept;

    assign out_adv    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && out_adv;
    assign o_s_tready = !r_in_valid || out_adv;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_item.cmd              = i_s_tuser;
        n_in_item.tick_now         = i_s_tdata[31:0];
        n_in_item.motor_waiting    = i_s_tdata[32];
        n_in_item.movement_waiting = i_s_tdata[33];
        n_in_item.motor_faulted    = i_s_tdata[34];
        n_in_item.movement_faulted = i_s_tdata[35];
        n_in_item.homing_active    = i_s_tdata[36];
        n_in_item.limit_switches   = i_s_tdata[42:37];
        n_in_item.motor_stopped    = i_s_tdata[43];
        n_in_item.movement_stopped = i_s_tdata[44];
    end

    msup_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_max_cycle (r_max_cycle),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_cycle <= MaxCycleReset;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_cycle <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_item <= n_in_item;
        end
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutDataW-$bits(t_result)){1'b0}}, r_out};

    // a stop request only comes out of stopping or while entering error
    a_stop_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stop_request) |->
            (r_out.mode == MODE_STOPPING || r_out.mode == MODE_ERROR))
        else $error("stop request outside stopping");

    // a subsystem reset always comes with clear, security flag and idle mode
    a_reset_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.subsystem_reset) |->
            (r_out.clear_errors && r_out.mode == MODE_IDLE
             && r_out.error_flags == FLAG_SECURITY))
        else $error("inconsistent subsystem reset beat");

    // pass is granted only on the move into watching
    a_pass_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pass_grant) |->
            (r_out.mode == MODE_WATCHING && !r_out.stop_request
             && r_out.error_flags == '0))
        else $error("pass grant outside watching");

    // a beat in the result register is not lost while the receiver stalls
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> r_out_valid)
        else $error("result beat dropped");

endmodule

@@ sv/msup_step.sv @@
// ----------------------------------------------------------------------------
// msup_step
// Supervisor state machine: evaluates one registered item per cycle unless
// stalled; sets mode, reset latch and last cycle-check tick as it moves on.
// ----------------------------------------------------------------------------
module msup_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  msup_pkg::t_in_item            i_item,
    input  logic [msup_pkg::CycleW-1:0]   i_max_cycle,
    output msup_pkg::t_result             o_result
);
    import msup_pkg::*;

    t_state             r_state, n_state;
    logic               r_reset_pending, n_reset_pending;
    logic [TickW-1:0]   r_last_tick, n_last_tick;
    logic [TickW-1:0]   gap;
    t_result            res;

    assign gap = i_item.tick_now - r_last_tick;

    always_comb begin
        n_state         = r_state;
        n_reset_pending = r_reset_pending;
        n_last_tick     = r_last_tick;
        res             = '0;
        if (i_item.cmd == CMD_RESET) begin
            // reset request only sticks in error mode
            if (r_state == ST_ERROR) begin
                n_reset_pending = 1'b1;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_item.motor_waiting && i_item.movement_waiting) begin
                        res.pass_grant = 1'b1;
                        n_state        = ST_WATCHING;
                    end
                end
                ST_WATCHING: begin
                    if (i_item.motor_faulted || i_item.movement_faulted) begin
                        n_state = ST_STOPPING;
                    end else if (!i_item.homing_active && (i_item.limit_switches != '0)) begin
                        res.error_flags = {1'b0, i_item.limit_switches, 1'b0};
                        n_state         = ST_STOPPING;
                    end else begin
                        n_last_tick = i_item.tick_now;
                        if (gap > {{(TickW-CycleW){1'b0}}, i_max_cycle}) begin
                            res.error_flags = FLAG_OVERRUN;
                            n_state         = ST_STOPPING;
                        end
                    end
                end
                ST_STOPPING: begin
                    res.stop_request = 1'b1;
                    if (i_item.motor_stopped && i_item.movement_stopped) begin
                        n_state = ST_ERROR;
                    end
                end
                default: begin
                    if (r_reset_pending) begin
                        res.subsystem_reset = 1'b1;
                        res.clear_errors    = 1'b1;
                        n_reset_pending     = 1'b0;
                        n_state             = ST_IDLE;
                    end
                    res.error_flags = FLAG_SECURITY;
                end
            endcase
        end
        res.mode = mode_code(n_state);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_reset_pending <= 1'b0;
            r_last_tick     <= '0;
        end else if (i_fire) begin
            r_state         <= n_state;
            r_reset_pending <= n_reset_pending;
            r_last_tick     <= n_last_tick;
        end
    end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motion_safety_supervisor_core: status beats are
// queued by a sequencer, driven on the s channel, and every accepted beat is
// run through a local model of the supervisor. Result beats on the m channel
// are compared field by field against the predicted results in order.
// ----------------------------------------------------------------------------
module testbench;
    import msup_pkg::*;

    localparam int CycleLimit = 300000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [InDataW-1:0]    i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OutDataW-1:0]   o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CycleW-1:0]     i_cfg_data = '0;

    motion_safety_supervisor_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_item    status_beats[$];
    t_result     predicted_results[$];

    // model state
    logic [1:0]        mode_q = MODE_IDLE;
    logic              reset_latched = 1'b0;
    logic [TickW-1:0]  last_tick_q = '0;
    logic [CycleW-1:0] max_gap = MaxCycleReset;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          rx_hold_cycles = 0;
    bit          in_taken = 1'b0;
    logic [31:0] gen_tick = '0;
    int          cycles = 0;
    int          n_fail = 0;
    int          beats_in = 0;
    int          results_checked = 0;
    int          n_overruns = 0;
    int          n_switch_trips = 0;
    int          n_restarts = 0;
    t_result     got;
    t_result     want;

    function automatic t_result supervise(input t_in_item b);
        t_result     r;
        logic [31:0] gap;
        r = '0;
        if (b.cmd == CMD_RESET) begin
            if (mode_q == MODE_ERROR) reset_latched = 1'b1;
        end else begin
            case (mode_q)
                MODE_IDLE: begin
                    if (b.motor_waiting && b.movement_waiting) begin
                        r.pass_grant = 1'b1;
                        mode_q = MODE_WATCHING;
                    end
                end
                MODE_WATCHING: begin
                    if (b.motor_faulted || b.movement_faulted) begin
                        mode_q = MODE_STOPPING;
                    end else if (!b.homing_active && b.limit_switches != '0) begin
                        r.error_flags = {1'b0, b.limit_switches, 1'b0};
                        mode_q = MODE_STOPPING;
                        n_switch_trips++;
                    end else begin
                        // wrapping difference, tick stored once this check is reached
                        gap = b.tick_now - last_tick_q;
                        last_tick_q = b.tick_now;
                        if (gap > {24'd0, max_gap}) begin
                            r.error_flags = FLAG_OVERRUN;
                            mode_q = MODE_STOPPING;
                            n_overruns++;
                        end
                    end
                end
                MODE_STOPPING: begin
                    r.stop_request = 1'b1;
                    if (b.motor_stopped && b.movement_stopped) mode_q = MODE_ERROR;
                end
                default: begin
                    if (reset_latched) begin
                        r.subsystem_reset = 1'b1;
                        r.clear_errors = 1'b1;
                        reset_latched = 1'b0;
                        mode_q = MODE_IDLE;
                        n_restarts++;
                    end
                    r.error_flags = FLAG_SECURITY;
                end
            endcase
        end
        r.mode = mode_q;
        return r;
    endfunction

    // waiting/faulted/stopped: bit0 motor, bit1 movement
    function automatic t_in_item tick_beat(input logic [31:0] tick, input logic [1:0] waiting,
                                           input logic [1:0] faulted, input logic homing,
                                           input logic [5:0] sw, input logic [1:0] stopped);
        t_in_item b;
        b.cmd = CMD_TICK;
        b.tick_now = tick;
        b.motor_waiting = waiting[0];
        b.movement_waiting = waiting[1];
        b.motor_faulted = faulted[0];
        b.movement_faulted = faulted[1];
        b.homing_active = homing;
        b.limit_switches = sw;
        b.motor_stopped = stopped[0];
        b.movement_stopped = stopped[1];
        return b;
    endfunction

    function automatic t_in_item noise_beat();
        return tick_beat($urandom, 2'($urandom_range(3)), 2'($urandom_range(3)),
                         1'($urandom_range(1)), 6'($urandom_range(63)),
                         2'($urandom_range(3)));
    endfunction

    function automatic t_in_item reset_beat();
        t_in_item b;
        b = noise_beat();
        b.cmd = CMD_RESET;
        return b;
    endfunction

    // one pass idle -> watching -> stopping -> error -> idle with random content
    function automatic int queue_episode(input logic [7:0] lim);
        int         n;
        int         k;
        logic       homing;
        t_in_item   b;
        n = 0;
        k = $urandom_range(2);
        repeat (k) begin
            b = noise_beat();
            b.motor_waiting = 1'b0;
            if ($urandom_range(1)) begin
                b.motor_waiting = 1'b1;
                b.movement_waiting = 1'b0;
            end
            status_beats.push_back(b);
            n++;
        end
        b = noise_beat();
        b.motor_waiting = 1'b1;
        b.movement_waiting = 1'b1;
        status_beats.push_back(b);
        n++;
        k = $urandom_range(1, 8);
        repeat (k) begin
            if ($urandom_range(9) == 0) begin
                status_beats.push_back(reset_beat());
            end else begin
                gen_tick += $urandom_range(lim);
                homing = 1'($urandom_range(1));
                status_beats.push_back(tick_beat(gen_tick, 2'($urandom_range(3)), 2'b00, homing,
                                       homing ? 6'($urandom_range(63)) : 6'd0,
                                       2'($urandom_range(3))));
            end
            n++;
        end
        case ($urandom_range(2))
            0: begin
                b = noise_beat();
                b.motor_faulted = 1'($urandom_range(1));
                b.movement_faulted = !b.motor_faulted | 1'($urandom_range(1));
            end
            1: begin
                b = tick_beat(gen_tick, 2'($urandom_range(3)), 2'b00, 1'b0,
                              6'($urandom_range(1, 63)), 2'($urandom_range(3)));
            end
            default: begin
                gen_tick += 32'(lim) + 1 + $urandom_range(($urandom_range(3) == 0) ? 100000 : 3);
                b = tick_beat(gen_tick, 2'($urandom_range(3)), 2'b00, 1'($urandom_range(1)),
                              6'd0, 2'($urandom_range(3)));
            end
        endcase
        status_beats.push_back(b);
        n++;
        k = $urandom_range(3);
        repeat (k) begin
            b = ($urandom_range(4) == 0) ? reset_beat() : noise_beat();
            if (b.motor_stopped) b.movement_stopped = 1'b0;
            status_beats.push_back(b);
            n++;
        end
        b = noise_beat();
        b.motor_stopped = 1'b1;
        b.movement_stopped = 1'b1;
        status_beats.push_back(b);
        n++;
        k = $urandom_range(2);
        repeat (k) begin
            status_beats.push_back(noise_beat());
            n++;
        end
        k = $urandom_range(1, 2);
        repeat (k) begin
            status_beats.push_back(reset_beat());
            n++;
        end
        status_beats.push_back(noise_beat());
        return n + 1;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
            n_fail++;
        end
    endtask

    // acceptance, prediction and result checking, all sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) max_gap = i_cfg_data;
            in_taken = i_s_tvalid && o_s_tready;
            if (in_taken) begin
                predicted_results.push_back(supervise(status_beats.pop_front()));
                beats_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = t_result'(o_m_tdata[13:0]);
                if (predicted_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, got %0h",
                             $time, o_m_tdata);
                    n_fail++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("mode", 8'(want.mode), 8'(got.mode));
                    check_field("pass_grant", 8'(want.pass_grant), 8'(got.pass_grant));
                    check_field("stop_request", 8'(want.stop_request), 8'(got.stop_request));
                    check_field("subsystem_reset", 8'(want.subsystem_reset),
                                8'(got.subsystem_reset));
                    check_field("clear_errors", 8'(want.clear_errors), 8'(got.clear_errors));
                    check_field("error_flags", want.error_flags, got.error_flags);
                    check_field("tdata padding", 8'd0, 8'(o_m_tdata[15:14]));
                    results_checked++;
                end
            end
        end
    end

    // s channel driver: hold a beat until taken, then offer the next one or idle
    always @(negedge i_clk) begin
        if (!i_s_tvalid || in_taken) begin
            if (status_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser <= status_beats[0].cmd;
                i_s_tdata <= {3'b000, status_beats[0].movement_stopped,
                              status_beats[0].motor_stopped, status_beats[0].limit_switches,
                              status_beats[0].homing_active, status_beats[0].movement_faulted,
                              status_beats[0].motor_faulted, status_beats[0].movement_waiting,
                              status_beats[0].motor_waiting, status_beats[0].tick_now};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // m channel ready: random stalls, or a long hold-off counted down here
    always @(negedge i_clk) begin
        if (rx_hold_cycles != 0) begin
            i_m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("motion_safety_supervisor_core verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (status_beats.size() != 0 || predicted_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_gap(input logic [CycleW-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] lim, input int idle_pct, input int stall_pct,
                             input int count, input int hold);
        int made;
        made = 0;
        write_max_gap(lim);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        rx_hold_cycles = hold;
        gen_tick = last_tick_q;
        while (made < count) begin
            if ($urandom_range(99) < 15) begin
                status_beats.push_back(($urandom_range(3) == 0) ? reset_beat() : noise_beat());
                made++;
            end else begin
                made += queue_episode(lim);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset-value cycle limit of 4, last tick starts at zero
        status_beats.push_back(reset_beat());                              // ignored in idle
        status_beats.push_back(tick_beat(32'd9, 2'b01, 2'b11, 1'b0, 6'h3F, 2'b11));
        status_beats.push_back(tick_beat(32'd9, 2'b11, 2'b11, 1'b0, 6'h3F, 2'b11));
        status_beats.push_back(tick_beat(32'd2, 2'b00, 2'b00, 1'b0, 6'h00, 2'b00));
        status_beats.push_back(tick_beat(32'd6, 2'b11, 2'b00, 1'b0, 6'h00, 2'b11)); // gap at max
        status_beats.push_back(tick_beat(32'd6, 2'b00, 2'b00, 1'b1, 6'h3F, 2'b00)); // homing
        status_beats.push_back(reset_beat());                              // ignored in watching
        status_beats.push_back(tick_beat(32'hFFFF_FFFE, 2'b00, 2'b00, 1'b0, 6'h00, 2'b00));
        status_beats.push_back(tick_beat(32'd0, 2'b00, 2'b00, 1'b0, 6'h00, 2'b01));
        status_beats.push_back(reset_beat());                              // ignored in stopping
        status_beats.push_back(tick_beat(32'd0, 2'b00, 2'b00, 1'b0, 6'h00, 2'b11));
        status_beats.push_back(tick_beat(32'hFFFF_FFFF, 2'b11, 2'b11, 1'b1, 6'h3F, 2'b11));
        status_beats.push_back(reset_beat());
        status_beats.push_back(reset_beat());
        status_beats.push_back(tick_beat(32'd0, 2'b00, 2'b00, 1'b0, 6'h00, 2'b00)); // restart
        status_beats.push_back(tick_beat(32'd0, 2'b11, 2'b00, 1'b0, 6'h00, 2'b00));
        status_beats.push_back(tick_beat(32'd1, 2'b00, 2'b00, 1'b0, 6'h00, 2'b00)); // wraps
        status_beats.push_back(tick_beat(32'd2, 2'b00, 2'b01, 1'b0, 6'h3F, 2'b00)); // motor
        status_beats.push_back(tick_beat(32'd0, 2'b00, 2'b00, 1'b0, 6'h00, 2'b11));
        status_beats.push_back(reset_beat());
        status_beats.push_back(tick_beat(32'd0, 2'b00, 2'b00, 1'b0, 6'h00, 2'b00));
        status_beats.push_back(tick_beat(32'd0, 2'b11, 2'b00, 1'b0, 6'h00, 2'b00));
        status_beats.push_back(tick_beat(32'd2, 2'b00, 2'b10, 1'b0, 6'h00, 2'b00)); // movement
        status_beats.push_back(tick_beat(32'd0, 2'b00, 2'b00, 1'b0, 6'h00, 2'b11));
        status_beats.push_back(reset_beat());
        wait_drained();

        run_phase(8'd0, 0, 0, 170, 200);
        run_phase(8'd255, 76, 0, 170, 0);
        run_phase(8'($urandom_range(2, 254)), 0, 76, 170, 0);
        run_phase(8'd1, 30, 30, 170, 0);
        run_phase(8'd4, 30, 0, 170, 0);
        // an error state with a latched reset would restart on this beat
        status_beats.push_back(tick_beat(32'd0, 2'b00, 2'b00, 1'b0, 6'h00, 2'b00));
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d status beats over six cycle-limit settings, %0d results checked",
                 beats_in, results_checked);
        $display("trips seen: %0d overruns, %0d limit switch, %0d restarts from error",
                 n_overruns, n_switch_trips, n_restarts);
        if (n_fail == 0) begin
            $display("motion_safety_supervisor_core verification clean");
        end else begin
            $display("motion_safety_supervisor_core verification failed");
        end
        $finish;
    end

endmodule

@@ motion_safety_supervisor_core.f @@
sv/msup_pkg.sv
sv/msup_step.sv
sv/motion_safety_supervisor_core.sv
dv/testbench.sv
